@@ design/kmtpq_pkg.sv @@
package kmtpq_pkg;

  localparam int ACTION_W  = 3;
  localparam int KEY_W     = 10;
  localparam int TIME_W    = 32;
  localparam int ENTRIES_W = 11;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH   = 3'd0,
    ACT_UPDATE = 3'd1,
    ACT_ERASE  = 3'd2,
    ACT_SEARCH = 3'd3,
    ACT_POP    = 3'd4,
    ACT_PEEK   = 3'd5
  } action_e;

endpackage

@@ design/kmtpq_if.sv @@
interface kmtpq_in_if;
  import kmtpq_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [KEY_W-1:0]    key;
  logic [TIME_W-1:0]   time_in;

  modport source (output valid, action, key, time_in, input ready);
  modport sink (input valid, action, key, time_in, output ready);
endinterface

interface kmtpq_out_if;
  import kmtpq_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 found;
  logic [KEY_W-1:0]     key_out;
  logic [TIME_W-1:0]    time_out;
  logic [ENTRIES_W-1:0] entries;
  logic                 status;

  modport source (output valid, found, key_out, time_out, entries, status, input ready);
  modport sink (input valid, found, key_out, time_out, entries, status, output ready);
endinterface

@@ design/kmtpq_ram.sv @@
module kmtpq_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/keyed_min_time_priority_queue_core.sv @@
// Keyed minimum-time queue: one time per key, kept with an occupied flag in a single-port
// RAM of KEYS words. After reset the block clears the RAM word by word and takes no beat
// until that is done. Push, update, erase and search go through accept, RAM read with
// write-back, and result. Pop and peek read every slot through the one RAM port, one slot
// per cycle, then give the minimum; on an empty queue they skip the scan.
// One beat is worked on at a time; a new beat may be accepted while the last result still
// waits at the output register.
module keyed_min_time_priority_queue_core #(
  parameter int KEYS      = 1024,
  parameter int TIME_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  kmtpq_in_if.sink    req_i,
  kmtpq_out_if.source rsp_o
);
  import kmtpq_pkg::*;

  localparam int AW = $clog2(KEYS);
  localparam int CW = $clog2(KEYS + 1);
  localparam int MW = TIME_BITS + 1;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_SCAN  = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0]           state_q, state_d;
  logic [AW:0]          scan_q, scan_d;
  logic                 cmp_v_q, cmp_v_d;
  logic [AW-1:0]        cmp_addr_q, cmp_addr_d;
  logic                 have_q, have_d;
  logic [AW-1:0]        kmin_q, kmin_d;
  logic [TIME_BITS-1:0] tmin_q, tmin_d;
  logic [CW-1:0]        count_q, count_d;
  logic [ACTION_W-1:0]  act_q, act_d;
  logic [AW-1:0]        addr_q, addr_d;
  logic [TIME_BITS-1:0] time_q, time_d;

  logic                 res_found_q, res_found_d;
  logic [KEY_W-1:0]     res_key_q, res_key_d;
  logic [TIME_W-1:0]    res_time_q, res_time_d;
  logic                 res_status_q, res_status_d;

  logic                 out_valid_q, out_valid_d;
  logic                 out_found_q;
  logic [KEY_W-1:0]     out_key_q;
  logic [TIME_W-1:0]    out_time_q;
  logic [ENTRIES_W-1:0] out_entries_q;
  logic                 out_status_q;
  logic                 out_load;

  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_addr;
  logic [MW-1:0]        ram_wdata, ram_rdata;

  logic                 accept;
  logic [63:0]          t_in_ext, rd_time_ext, tmin_ext, time_q_ext;
  logic [31:0]          key_in_ext, kmin_ext, cnt_ext;
  logic                 key_ok;
  logic                 rd_occ;
  logic [TIME_BITS-1:0] rd_time;

  kmtpq_ram #(
    .WIDTH (MW),
    .DEPTH (KEYS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign accept      = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == ST_IDLE);

  assign t_in_ext    = 64'(req_i.time_in);
  assign key_in_ext  = 32'(req_i.key);
  assign key_ok      = key_in_ext < 32'(KEYS);
  assign rd_occ      = ram_rdata[TIME_BITS];
  assign rd_time     = ram_rdata[TIME_BITS-1:0];
  assign rd_time_ext = 64'(rd_time);
  assign tmin_ext    = 64'(tmin_q);
  assign time_q_ext  = 64'(time_q);
  assign kmin_ext    = 32'(kmin_q);
  assign cnt_ext     = 32'(count_q);

  always_comb begin
    state_d      = state_q;
    scan_d       = scan_q;
    cmp_v_d      = cmp_v_q;
    cmp_addr_d   = cmp_addr_q;
    have_d       = have_q;
    kmin_d       = kmin_q;
    tmin_d       = tmin_q;
    count_d      = count_q;
    act_d        = act_q;
    addr_d       = addr_q;
    time_d       = time_q;
    res_found_d  = res_found_q;
    res_key_d    = res_key_q;
    res_time_d   = res_time_q;
    res_status_d = res_status_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_addr     = addr_q;
    ram_wdata    = '0;
    out_load     = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = scan_q[AW-1:0];
        ram_wdata = '0;
        scan_d    = scan_q + (AW+1)'(1);
        if (scan_q[AW-1:0] == AW'(KEYS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          act_d        = req_i.action;
          addr_d       = key_in_ext[AW-1:0];
          time_d       = t_in_ext[TIME_BITS-1:0];
          res_found_d  = 1'b0;
          res_key_d    = req_i.key;
          res_time_d   = '0;
          res_status_d = 1'b0;
          unique case (req_i.action)
            ACT_PUSH, ACT_UPDATE, ACT_ERASE, ACT_SEARCH: begin
              if (key_ok) begin
                ram_re   = 1'b1;
                ram_addr = key_in_ext[AW-1:0];
                state_d  = ST_READ;
              end else begin
                state_d = ST_DONE;
              end
            end
            ACT_POP, ACT_PEEK: begin
              if (count_q == '0) begin
                res_key_d    = '0;
                res_status_d = 1'b1;
                state_d      = ST_DONE;
              end else begin
                scan_d  = '0;
                cmp_v_d = 1'b0;
                have_d  = 1'b0;
                state_d = ST_SCAN;
              end
            end
            default: begin
              res_key_d = '0;
              state_d   = ST_DONE;
            end
          endcase
        end
      end
      ST_READ: begin
        res_found_d = rd_occ;
        ram_addr    = addr_q;
        unique case (act_q)
          ACT_PUSH: begin
            if (!rd_occ) begin
              ram_we     = 1'b1;
              ram_wdata  = {1'b1, time_q};
              count_d    = count_q + CW'(1);
              res_time_d = time_q_ext[TIME_W-1:0];
            end else begin
              res_time_d = rd_time_ext[TIME_W-1:0];
            end
          end
          ACT_UPDATE: begin
            ram_we     = 1'b1;
            ram_wdata  = {1'b1, time_q};
            res_time_d = time_q_ext[TIME_W-1:0];
            if (!rd_occ) begin
              count_d = count_q + CW'(1);
            end
          end
          ACT_ERASE: begin
            if (rd_occ) begin
              ram_we     = 1'b1;
              ram_wdata  = {1'b0, rd_time};
              count_d    = count_q - CW'(1);
              res_time_d = rd_time_ext[TIME_W-1:0];
            end
          end
          default: begin
            if (rd_occ) begin
              res_time_d = rd_time_ext[TIME_W-1:0];
            end
          end
        endcase
        state_d = ST_DONE;
      end
      ST_SCAN: begin
        if (scan_q < (AW+1)'(KEYS)) begin
          ram_re     = 1'b1;
          ram_addr   = scan_q[AW-1:0];
          scan_d     = scan_q + (AW+1)'(1);
          cmp_v_d    = 1'b1;
          cmp_addr_d = scan_q[AW-1:0];
        end else begin
          cmp_v_d = 1'b0;
        end
        if (cmp_v_q) begin
          // strict compare keeps the lowest key on equal times
          if (rd_occ && (!have_q || rd_time < tmin_q)) begin
            have_d = 1'b1;
            kmin_d = cmp_addr_q;
            tmin_d = rd_time;
          end
          if (cmp_addr_q == AW'(KEYS - 1)) begin
            state_d = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        res_found_d  = 1'b1;
        res_key_d    = kmin_ext[KEY_W-1:0];
        res_time_d   = tmin_ext[TIME_W-1:0];
        res_status_d = 1'b0;
        if (act_q == ACT_POP) begin
          ram_we    = 1'b1;
          ram_addr  = kmin_q;
          ram_wdata = {1'b0, tmin_q};
          count_d   = count_q - CW'(1);
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      scan_q      <= '0;
      cmp_v_q     <= 1'b0;
      have_q      <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      scan_q      <= scan_d;
      cmp_v_q     <= cmp_v_d;
      have_q      <= have_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_addr_q   <= cmp_addr_d;
    kmin_q       <= kmin_d;
    tmin_q       <= tmin_d;
    act_q        <= act_d;
    addr_q       <= addr_d;
    time_q       <= time_d;
    res_found_q  <= res_found_d;
    res_key_q    <= res_key_d;
    res_time_q   <= res_time_d;
    res_status_q <= res_status_d;
    if (out_load) begin
      out_found_q   <= res_found_q;
      out_key_q     <= res_key_q;
      out_time_q    <= res_time_q;
      out_entries_q <= cnt_ext[ENTRIES_W-1:0];
      out_status_q  <= res_status_q;
    end
  end

  assign rsp_o.valid    = out_valid_q;
  assign rsp_o.found    = out_found_q;
  assign rsp_o.key_out  = out_key_q;
  assign rsp_o.time_out = out_time_q;
  assign rsp_o.entries  = out_entries_q;
  assign rsp_o.status   = out_status_q;

endmodule
